// ===== hw/rtl/esc_pkg.sv =====
package esc_pkg;

  localparam int unsigned DivW    = 64;
  localparam int unsigned CfgIdxW = 8;
  localparam int unsigned CfgW    = 64;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] RegTempCal  = 8'd0;
  localparam logic [CfgIdxW-1:0] RegPressCalA = 8'd1;
  localparam logic [CfgIdxW-1:0] RegPressCalB = 8'd2;
  localparam logic [CfgIdxW-1:0] RegPressCalC = 8'd3;
  localparam logic [CfgIdxW-1:0] RegHumCal    = 8'd4;

  // Results that ride alongside the pressure division.
  typedef struct packed {
    logic               status;
    logic signed [31:0] temp;
    logic [9:0]         hum;
    logic               zero_div;
  } side_t;

endpackage

// ===== hw/rtl/env_sensor_compensation_unit.sv =====
// Environmental sensor compensation pipeline.
// Input stream: s_axis_tdata carries one 8-byte burst readout (first byte in
// bits 63:56), s_axis_tuser carries the bus-ok flag. Output stream:
// m_axis_tdata carries temperature in centidegrees, pressure in pascals and
// humidity in permille; m_axis_tuser is the error status (1 = bus failure or
// sentinel reading, all values then zero).
// Calibration is written through the cfg channel (index 0 temp_cal,
// 1..3 pressure words, 4 hum_cal); cfg_ready is always high and writes are
// meant to happen while the pipeline is empty.
// An accepted input beat passes through 13 arithmetic stages, 64 stages of the
// restoring pressure divider (one quotient bit per stage), and 4 stages of
// pressure post-processing on its way to its output beat.
// Throughput is one beat per cycle while the receiver does not stall.
// Reset clears the calibration registers and all valid bits.
// When the receiver stalls, the whole pipeline holds in place and
// s_axis_tready drops; nothing is lost or repeated.
module env_sensor_compensation_unit import esc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [63:0]        s_axis_tdata,   // burst[63:0]
  input  logic [0:0]         s_axis_tuser,   // bus_ok[0]
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [71:0]        m_axis_tdata,   // temperature[31:0], pressure[55:32], humidity[65:56]
  output logic [0:0]         m_axis_tuser,   // status[0]
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [CfgW-1:0]    cfg_data_i
);

  // Configuration.
  logic [47:0] temp_cal_q;
  logic [63:0] press_a_q, press_b_q, hum_cal_q;
  logic [15:0] press_c_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      temp_cal_q <= '0;
      press_a_q  <= '0;
      press_b_q  <= '0;
      press_c_q  <= '0;
      hum_cal_q  <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        RegTempCal:   temp_cal_q <= cfg_data_i[47:0];
        RegPressCalA: press_a_q  <= cfg_data_i;
        RegPressCalB: press_b_q  <= cfg_data_i;
        RegPressCalC: press_c_q  <= cfg_data_i[15:0];
        RegHumCal:    hum_cal_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic [15:0]        t1, p1;
  logic signed [15:0] t2, t3, p2, p3, p4, p5, p6, p7, p8, p9, h2;
  logic [7:0]         h1, h3;
  logic signed [11:0] h4, h5;
  logic signed [7:0]  h6;

  assign t1 = temp_cal_q[15:0];
  assign t2 = $signed(temp_cal_q[31:16]);
  assign t3 = $signed(temp_cal_q[47:32]);
  assign p1 = press_a_q[15:0];
  assign p2 = $signed(press_a_q[31:16]);
  assign p3 = $signed(press_a_q[47:32]);
  assign p4 = $signed(press_a_q[63:48]);
  assign p5 = $signed(press_b_q[15:0]);
  assign p6 = $signed(press_b_q[31:16]);
  assign p7 = $signed(press_b_q[47:32]);
  assign p8 = $signed(press_b_q[63:48]);
  assign p9 = $signed(press_c_q);
  assign h1 = hum_cal_q[7:0];
  assign h2 = $signed(hum_cal_q[23:8]);
  assign h3 = hum_cal_q[31:24];
  assign h4 = $signed(hum_cal_q[43:32]);
  assign h5 = $signed(hum_cal_q[55:44]);
  assign h6 = $signed(hum_cal_q[63:56]);

  // Global advance: every stage moves when the output register can take a beat.
  logic adv;
  logic out_vld_q;
  assign adv           = !out_vld_q || m_axis_tready;
  assign s_axis_tready = adv;

  logic [19:0] praw_in, traw_in;
  logic [15:0] hraw_in;
  logic        err_in;
  assign praw_in = s_axis_tdata[63:44];
  assign traw_in = s_axis_tdata[39:20];
  assign hraw_in = s_axis_tdata[15:0];
  assign err_in  = !s_axis_tuser[0] || (praw_in == 20'h80000) || (traw_in == 20'h80000)
                   || (hraw_in == 16'h8000);

  // Carried fields.
  logic [13:1]        vld_q;
  logic [13:1]        err_q;
  logic [19:0]        praw_q [1:8];
  logic [15:0]        hraw_q [1:6];
  logic signed [31:0] tc_q   [5:13];
  logic signed [31:0] ta_q   [7:10];
  logic signed [63:0] n3_q   [10:13];
  logic signed [63:0] den_q  [10:13];
  logic signed [31:0] vv_q   [11:13];

  // Stage results.
  logic signed [18:0] a1_q;
  logic signed [17:0] d1_q;
  logic signed [31:0] m1_q, dd_q, v1_q, m2_q, tfine_q, hv_q;
  logic signed [32:0] w1_q;
  logic signed [63:0] sq_q, wp5_q, wp2_q, wp5s_q, wp2s_q, t6_q, t3p_q, w2_q, x_q, y_q, num_q;
  logic signed [31:0] h5v_q, a0_q, b0_q, ha_q, bb_q, ac_q, ch_q, tb_q, ss_q, hh_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[12:1], s_axis_tvalid};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      err_q     <= {err_q[12:1], err_in};
      praw_q[1] <= praw_in;
      for (int k = 2; k <= 8; k++) praw_q[k] <= praw_q[k-1];
      hraw_q[1] <= hraw_in;
      for (int k = 2; k <= 6; k++) hraw_q[k] <= hraw_q[k-1];
      for (int k = 6; k <= 13; k++) tc_q[k] <= tc_q[k-1];
      for (int k = 8; k <= 10; k++) ta_q[k] <= ta_q[k-1];
      for (int k = 11; k <= 13; k++) begin
        n3_q[k]  <= n3_q[k-1];
        den_q[k] <= den_q[k-1];
      end
      for (int k = 12; k <= 13; k++) vv_q[k] <= vv_q[k-1];

      // Temperature.
      a1_q    <= $signed({2'b00, traw_in[19:3]}) - $signed({2'b00, t1, 1'b0});
      d1_q    <= $signed({2'b00, traw_in[19:4]}) - $signed({2'b00, t1});
      m1_q    <= 32'(a1_q) * 32'(t2);
      dd_q    <= 32'(d1_q) * 32'(d1_q);
      v1_q    <= m1_q >>> 11;
      m2_q    <= (dd_q >>> 12) * 32'(t3);
      tfine_q <= v1_q + (m2_q >>> 14);
      tc_q[5] <= (tfine_q * 32'sd5 + 32'sd128) >>> 8;
      w1_q    <= 33'(tfine_q) - 33'sd128000;
      hv_q    <= tfine_q - 32'sd76800;

      // Pressure terms ahead of the division.
      sq_q   <= 64'(w1_q) * 64'(w1_q);
      wp5_q  <= 64'(w1_q) * 64'(p5);
      wp2_q  <= 64'(w1_q) * 64'(p2);
      t6_q   <= sq_q * 64'(p6);
      t3p_q  <= sq_q * 64'(p3);
      wp5s_q <= (wp5_q <<< 17) + (64'(p4) <<< 35);
      wp2s_q <= (wp2_q <<< 12) + (64'sd1 <<< 47);
      w2_q   <= t6_q + wp5s_q;
      x_q    <= (t3p_q >>> 8) + wp2s_q;
      y_q   <= x_q * $signed({48'b0, p1});
      num_q <= $signed({12'b0, 21'(21'd1048576 - {1'b0, praw_q[8]}), 31'b0}) - w2_q;
      den_q[10] <= y_q >>> 33;
      n3_q[10]  <= num_q * 64'sd3125;

      // Humidity.
      h5v_q   <= 32'(h5) * hv_q;
      a0_q    <= hv_q * 32'(h6);
      b0_q    <= hv_q * $signed({24'b0, h3});
      ta_q[7] <= ($signed({2'b00, hraw_q[6], 14'b0}) - (32'(h4) <<< 20) - h5v_q
                  + 32'sd16384) >>> 15;
      ha_q    <= a0_q >>> 10;
      bb_q    <= (b0_q >>> 11) + 32'sd32768;
      ac_q    <= ha_q * bb_q;
      ch_q    <= ((ac_q >>> 10) + 32'sd2097152) * 32'(h2);
      tb_q    <= (ch_q + 32'sd8192) >>> 14;
      vv_q[11] <= ta_q[10] * tb_q;
      ss_q    <= (vv_q[11] >>> 15) * (vv_q[11] >>> 15);
      hh_q    <= (ss_q >>> 7) * $signed({24'b0, h1});
    end
  end

  // Humidity clamp and scale, and division operand preparation.
  logic signed [31:0] vf;
  logic [28:0]        vc;
  logic [20:0]        pm;
  logic [63:0]        n3u, denu, div_num, div_den;
  logic               zero_div, div_neg;
  side_t              side_in;

  always_comb begin
    vf = vv_q[13] - (hh_q >>> 4);
    if (vf[31]) begin
      vc = '0;
    end else if ($unsigned(vf) > 32'd419430400) begin
      vc = 29'd419430400;
    end else begin
      vc = vf[28:0];
    end
    pm = ({4'b0, vc[28:12]} << 3) + ({4'b0, vc[28:12]} << 1);
    n3u      = n3_q[13];
    denu     = den_q[13];
    zero_div = (denu == '0);
    div_neg  = n3u[63] ^ denu[63];
    div_num  = n3u[63] ? ('0 - n3u) : n3u;
    div_den  = zero_div ? 64'd1 : (denu[63] ? ('0 - denu) : denu);
    side_in.status   = err_q[13];
    side_in.temp     = tc_q[13];
    side_in.hum      = pm[19:10];
    side_in.zero_div = zero_div;
  end

  logic            dv_vld;
  logic [DivW-1:0] dv_quo;
  side_t           dv_side;

  esc_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .vld_i  (vld_q[13]),
    .num_i  (div_num),
    .den_i  (div_den),
    .neg_i  (div_neg),
    .side_i (side_in),
    .vld_o  (dv_vld),
    .quo_o  (dv_quo),
    .side_o (dv_side)
  );

  // Pressure post-processing.
  logic [3:1]         pv_q;
  side_t              ps_q [1:3];
  logic signed [63:0] pp_q [1:3];
  logic signed [63:0] q13_q, p9q_q, p8p_q [1:2];
  logic [63:0]        ll_q;
  logic [31:0]        lh_q, hl_q;
  logic signed [63:0] pw1_q, pw2_q;
  logic [63:0]        prod;

  assign prod = ll_q + {lh_q + hl_q, 32'b0};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q      <= '0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      pv_q      <= {pv_q[2:1], dv_vld};
      out_vld_q <= pv_q[3];
    end
  end

  logic signed [31:0] out_tc_q;
  logic [23:0]        out_pa_q;
  logic [9:0]         out_hum_q;
  logic               out_st_q;
  logic signed [63:0] pf;

  assign pf = ((pp_q[3] + pw1_q + pw2_q) >>> 8) + (64'(p7) <<< 4);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pp_q[1]  <= $signed(dv_quo);
      ps_q[1]  <= dv_side;
      q13_q    <= $signed(dv_quo) >>> 13;
      p9q_q    <= 64'(p9) * ($signed(dv_quo) >>> 13);
      p8p_q[1] <= 64'(p8) * $signed(dv_quo);

      ll_q     <= {32'b0, p9q_q[31:0]} * {32'b0, q13_q[31:0]};
      lh_q     <= p9q_q[31:0] * q13_q[63:32];
      hl_q     <= p9q_q[63:32] * q13_q[31:0];
      pp_q[2]  <= pp_q[1];
      ps_q[2]  <= ps_q[1];
      p8p_q[2] <= p8p_q[1];

      pw1_q   <= $signed(prod) >>> 25;
      pw2_q   <= p8p_q[2] >>> 19;
      pp_q[3] <= pp_q[2];
      ps_q[3] <= ps_q[2];

      out_st_q  <= ps_q[3].status;
      out_tc_q  <= ps_q[3].status ? 32'sd0 : ps_q[3].temp;
      out_hum_q <= ps_q[3].status ? 10'd0 : ps_q[3].hum;
      out_pa_q  <= (ps_q[3].status || ps_q[3].zero_div) ? 24'd0 : pf[31:8];
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tuser  = out_st_q;
  assign m_axis_tdata  = {6'b0, out_hum_q, out_pa_q, out_tc_q};

endmodule

// ===== hw/rtl/esc_div.sv =====
module esc_div import esc_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            vld_i,
  input  logic [DivW-1:0] num_i,
  input  logic [DivW-1:0] den_i,
  input  logic            neg_i,
  input  side_t           side_i,
  output logic            vld_o,
  output logic [DivW-1:0] quo_o,
  output side_t           side_o
);

  // Each stage retires one quotient bit. Numerator bits leave the top of nq
  // while quotient bits enter at the bottom.
  logic [DivW-1:0] rem_q [1:DivW];
  logic [DivW-1:0] nq_q  [1:DivW];
  logic [DivW-1:0] den_q [1:DivW];
  logic            neg_q [1:DivW];
  side_t           side_q [1:DivW];
  logic [DivW:1]   vld_q;

  function automatic logic [2*DivW-1:0] div_step(logic [DivW-1:0] rem, logic [DivW-1:0] nq,
                                                 logic [DivW-1:0] den);
    logic [DivW-1:0] trial;
    logic            ge;
    trial = {rem[DivW-2:0], nq[DivW-1]};
    ge    = (trial >= den);
    div_step = {(ge ? trial - den : trial), nq[DivW-2:0], ge};
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[DivW-1:1], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      {rem_q[1], nq_q[1]} <= div_step('0, num_i, den_i);
      den_q[1]  <= den_i;
      neg_q[1]  <= neg_i;
      side_q[1] <= side_i;
      for (int k = 2; k <= DivW; k++) begin
        {rem_q[k], nq_q[k]} <= div_step(rem_q[k-1], nq_q[k-1], den_q[k-1]);
        den_q[k]  <= den_q[k-1];
        neg_q[k]  <= neg_q[k-1];
        side_q[k] <= side_q[k-1];
      end
    end
  end

  assign vld_o  = vld_q[DivW];
  assign quo_o  = neg_q[DivW] ? ('0 - nq_q[DivW]) : nq_q[DivW];
  assign side_o = side_q[DivW];

endmodule

// ===== tb/sv/tb_top.sv =====
module tb_top;
  import esc_pkg::*;

  localparam int unsigned NumRandom   = 2000;
  localparam int unsigned Latency     = 81;
  localparam int unsigned WatchdogMax = 20000;

  // An index that addresses no register.
  localparam logic [CfgIdxW-1:0] RegNone = 8'd9;

  typedef struct packed {
    logic [63:0] burst;
    logic        bus_ok;
  } readout_t;

  typedef struct packed {
    logic        status;
    logic [31:0] temp;
    logic [23:0] press;
    logic [9:0]  hum;
  } reading_t;

  logic clk_i;
  logic rst_ni;
  logic s_axis_tvalid, s_axis_tready;
  logic [63:0] s_axis_tdata;
  logic [0:0] s_axis_tuser;
  logic m_axis_tvalid, m_axis_tready;
  logic [71:0] m_axis_tdata;
  logic [0:0] m_axis_tuser;
  logic cfg_valid_i, cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i;
  logic [CfgW-1:0] cfg_data_i;

  env_sensor_compensation_unit u_top (.*);

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // Calibration copy used by the predictor.
  logic [47:0] cal_t;
  logic [63:0] cal_pa, cal_pb, cal_h;
  logic [15:0] cal_pc;

  readout_t pending_q[$];
  reading_t expected_q[$];
  int unsigned n_errors;
  int unsigned n_shown;
  bit stim_done;
  int unsigned idle_cycles;

  function automatic logic [31:0] sext32(logic [63:0] v, int unsigned w);
    logic [31:0] r;
    for (int i = 0; i < 32; i++) r[i] = (i < w) ? v[i] : v[w-1];
    return r;
  endfunction

  function automatic logic [63:0] sext64(logic [63:0] v, int unsigned w);
    logic [63:0] r;
    for (int i = 0; i < 64; i++) r[i] = (i < w) ? v[i] : v[w-1];
    return r;
  endfunction

  function automatic reading_t compensate(readout_t it);
    reading_t r;
    logic [31:0] praw, traw, hraw;
    logic [31:0] t1, t2, t3, tfine, d, v1, v2, tc;
    logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9, w1, w2, p, q, ua, ub, quo;
    logic [31:0] h1, h2, h3, h4, h5, h6, v, ta, tb, a, c, s;
    r = '0;
    praw = {12'd0, it.burst[63:44]};
    traw = {12'd0, it.burst[39:20]};
    hraw = {16'd0, it.burst[15:0]};
    if (!it.bus_ok || praw == 32'h80000 || traw == 32'h80000 || hraw == 32'h8000) begin
      r.status = 1'b1;
      return r;
    end
    t1 = {16'd0, cal_t[15:0]};
    t2 = sext32(cal_t >> 16, 16);
    t3 = sext32(cal_t >> 32, 16);
    v1 = $signed(((traw >> 3) - (t1 << 1)) * t2) >>> 11;
    d = (traw >> 4) - t1;
    v2 = $signed(($signed(d * d) >>> 12) * $signed(t3)) >>> 14;
    tfine = v1 + v2;
    tc = $signed(tfine * 5 + 32'd128) >>> 8;
    r.temp = tc;

    p1 = {48'd0, cal_pa[15:0]};
    p2 = sext64(cal_pa >> 16, 16);
    p3 = sext64(cal_pa >> 32, 16);
    p4 = sext64(cal_pa >> 48, 16);
    p5 = sext64(cal_pb, 16);
    p6 = sext64(cal_pb >> 16, 16);
    p7 = sext64(cal_pb >> 32, 16);
    p8 = sext64(cal_pb >> 48, 16);
    p9 = sext64({48'd0, cal_pc}, 16);
    w1 = sext64({32'd0, tfine}, 32) - 64'd128000;
    w2 = w1 * w1 * p6 + ((w1 * p5) << 17) + (p4 << 35);
    w1 = ($signed(w1 * w1 * p3) >>> 8) + $signed((w1 * p2) << 12);
    w1 = $signed(((64'd1 << 47) + w1) * p1) >>> 33;
    if (w1 != 0) begin
      p = 64'd1048576 - {32'd0, praw};
      p = ((p << 31) - w2) * 64'd3125;
      // Signed truncating division done on magnitudes so the min/-1 case wraps.
      ua = p[63] ? -p : p;
      ub = w1[63] ? -w1 : w1;
      quo = ua / ub;
      p = (p[63] != w1[63]) ? -quo : quo;
      q = $signed(p) >>> 13;
      w1 = $signed(p9 * q * q) >>> 25;
      w2 = $signed(p8 * p) >>> 19;
      p = ($signed(p + w1 + w2) >>> 8) + $signed(p7 << 4);
      r.press = p[31:8];
    end

    h1 = {24'd0, cal_h[7:0]};
    h2 = sext32(cal_h >> 8, 16);
    h3 = {24'd0, cal_h[31:24]};
    h4 = sext32(cal_h >> 32, 12);
    h5 = sext32(cal_h >> 44, 12);
    h6 = sext32(cal_h >> 56, 8);
    v = tfine - 32'd76800;
    ta = $signed((hraw << 14) - (h4 << 20) - (h5 * v) + 32'd16384) >>> 15;
    a = $signed(v * h6) >>> 10;
    c = ($signed($signed(a) * (($signed(v * h3) >>> 11) + 32'sd32768)) >>> 10)
        + 32'sd2097152;
    tb = $signed(c * h2 + 32'd8192) >>> 14;
    v = ta * tb;
    s = $signed(v) >>> 15;
    v = $signed(v) - ($signed(($signed(s * s) >>> 7) * $signed(h1)) >>> 4);
    if (v[31]) v = 0;
    else if (v > 32'd419430400) v = 32'd419430400;
    v = ((v >> 12) * 10) / 1024;
    r.hum = v[9:0];
    return r;
  endfunction

  // Driver: bursts of valid beats separated by random gaps.
  int unsigned burst_left, gap_left;
  bit hold_off;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_q.push_back(compensate(readout_t'({s_axis_tdata, s_axis_tuser[0]})));
        void'(pending_q.pop_front());
      end
      if (s_axis_tvalid && !s_axis_tready) begin
        // hold the beat until it is taken
      end else if (hold_off || pending_q.size() == 0) begin
        s_axis_tvalid <= 1'b0;
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        s_axis_tvalid <= 1'b0;
      end else begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= pending_q[0].burst;
        s_axis_tuser <= pending_q[0].bus_ok;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 40);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left <= burst_left - 1;
        end
      end
    end
  end

  // Receiver stall pattern switches mode whenever the low six bits of stall_cnt return to zero.
  int unsigned stall_mode, stall_cnt;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      stall_cnt <= stall_cnt + 1;
      if (stall_cnt[5:0] == 0) stall_mode <= $urandom_range(0, 3);
      case (stall_mode)
        0: m_axis_tready <= 1'b1;
        1: m_axis_tready <= 1'($urandom_range(0, 1));
        2: m_axis_tready <= (stall_cnt[3:0] < 12);
        default: m_axis_tready <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  // Monitor and watchdog.
  always @(posedge clk_i) begin
    reading_t got, want;
    if (rst_ni) begin
      idle_cycles <= ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                     ? 0 : idle_cycles + 1;
      if (idle_cycles > WatchdogMax) begin
        $display("status: fail");
        $finish;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = '{m_axis_tuser[0], m_axis_tdata[31:0], m_axis_tdata[55:32],
                m_axis_tdata[65:56]};
        if (expected_q.size() == 0) begin
          n_errors++;
          if (n_shown < 10) begin
            n_shown++;
            $display("unexpected output beat %h", got);
          end
        end else begin
          want = expected_q.pop_front();
          if (got != want) begin
            n_errors++;
            if (n_shown < 10) begin
              n_shown++;
              $display("mismatch: status %0d/%0d temp %0d/%0d press %0d/%0d hum %0d/%0d",
                       want.status, got.status, $signed(want.temp), $signed(got.temp),
                       want.press, got.press, want.hum, got.hum);
            end
          end
        end
      end
    end
  end

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [63:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      RegTempCal:   cal_t = val[47:0];
      RegPressCalA: cal_pa = val;
      RegPressCalB: cal_pb = val;
      RegPressCalC: cal_pc = val[15:0];
      RegHumCal:    cal_h = val;
      default: ;
    endcase
  endtask

  task automatic drain();
    wait (pending_q.size() == 0 && !s_axis_tvalid);
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (Latency + 10) @(posedge clk_i);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Mostly well-formed readouts: random raw values, seldom a sentinel or bus error.
  function automatic readout_t rand_readout();
    readout_t it;
    it.burst = rand64();
    it.bus_ok = ($urandom_range(0, 15) != 0);
    case ($urandom_range(0, 19))
      0: it.burst[63:44] = 20'h80000;
      1: it.burst[39:20] = 20'h80000;
      2: it.burst[15:0] = 16'h8000;
      default: ;
    endcase
    return it;
  endfunction

  // Plausible calibration set close to a real part, with random perturbations.
  task automatic load_typical();
    write_reg(RegTempCal, {16'(50 + $urandom_range(0, 50) - 25),
                           16'(26000 + $urandom_range(0, 2000)), 16'(27500 + $urandom_range(0, 2000))});
    write_reg(RegPressCalA, {16'(7000 + $urandom_range(0, 2000)), 16'(3000 + $urandom_range(0, 1000)),
                             16'(-10600 + $urandom_range(0, 800)), 16'(36000 + $urandom_range(0, 2000))});
    write_reg(RegPressCalB, {16'(-12000 + $urandom_range(0, 2000)), 16'(15000 + $urandom_range(0, 2000)),
                             16'(-7), 16'(140 + $urandom_range(0, 100))});
    write_reg(RegPressCalC, 64'(16'(4000 + $urandom_range(0, 2000))));
    write_reg(RegHumCal, {8'(30), 12'(50), 12'(320), 8'(0), 16'(360), 8'(75)});
  endtask

  initial begin
    readout_t it;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    m_axis_tready = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    {cal_t, cal_pa, cal_pb, cal_pc, cal_h} = '0;
    n_errors = 0;
    n_shown = 0;
    idle_cycles = 0;
    burst_left = 0;
    gap_left = 0;
    hold_off = 1'b0;
    stall_mode = 0;
    stall_cnt = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: reset calibration gives a zero divisor; then field extremes.
    pending_q.push_back('{64'h0, 1'b1});
    pending_q.push_back('{64'hFFFF_FFFF_FFFF_FFFF, 1'b1});
    pending_q.push_back('{64'h1234_5678_9ABC_DEF0, 1'b0});
    drain();
    load_typical();
    pending_q.push_back('{64'h5A5A_5000_7E7E_6000 | 64'h6E00, 1'b1});
    pending_q.push_back('{64'h0, 1'b1});
    pending_q.push_back('{64'hFFFF_FFFF_FFFF_FFFF, 1'b1});
    pending_q.push_back('{64'h8000_0012_3450_1234, 1'b1});
    pending_q.push_back('{64'h5000_0080_0000_1234, 1'b1});
    pending_q.push_back('{64'h5000_0070_0000_8000, 1'b1});
    pending_q.push_back('{64'h5000_0070_0000_7FFF, 1'b1});
    pending_q.push_back('{64'h5000_0070_0000_6000, 1'b0});
    pending_q.push_back('{64'h7FFF_F07F_FFF0_FFFF, 1'b1});
    pending_q.push_back('{64'h0000_0000_0010_0000, 1'b1});
    // Sender pauses partway through until every result is back.
    while (pending_q.size() > 5) @(posedge clk_i);
    hold_off = 1'b1;
    do @(posedge clk_i); while (s_axis_tvalid || expected_q.size() != 0);
    hold_off = 1'b0;
    drain();

    // Extreme calibration words.
    write_reg(RegTempCal, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(RegPressCalA, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(RegPressCalB, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(RegPressCalC, 64'hFFFF);
    write_reg(RegHumCal, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(RegNone, 64'h0123_4567_89AB_CDEF);
    for (int i = 0; i < 100; i++) pending_q.push_back(rand_readout());
    drain();
    write_reg(RegTempCal, {16'h8000, 16'h8000, 16'h0000});
    write_reg(RegPressCalA, {16'h8000, 16'h8000, 16'h8000, 16'h0001});
    write_reg(RegPressCalB, {16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000});
    write_reg(RegPressCalC, 64'h8000);
    write_reg(RegHumCal, {8'h80, 12'h800, 12'h7FF, 8'hFF, 16'h8000, 8'hFF});
    for (int i = 0; i < 100; i++) pending_q.push_back(rand_readout());
    drain();

    // Random phases: mostly typical calibration, some fully random.
    for (int ph = 0; ph < 9; ph++) begin
      if (ph % 3 == 2) begin
        write_reg(RegTempCal, rand64());
        write_reg(RegPressCalA, rand64());
        write_reg(RegPressCalB, rand64());
        write_reg(RegPressCalC, rand64());
        write_reg(RegHumCal, rand64());
      end else begin
        load_typical();
      end
      for (int i = 0; i < NumRandom / 9; i++) begin
        it = rand_readout();
        // Keep most temperature raws in a realistic band.
        if ($urandom_range(0, 3) != 0) it.burst[39:20] = 20'($urandom_range(400000, 600000));
        pending_q.push_back(it);
      end
      drain();
    end

    if (n_errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
